@@ rtl/full_linear_convolution_fir_unit_macros.svh @@
// Assertion helpers, used by the top-level unit to check its own logic.
// All of them sample on clk_i and are switched off while rst_ni is low.
`ifndef FULL_LINEAR_CONVOLUTION_FIR_UNIT_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_FIR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FLCFIR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("flcfir assertion failed");

// Next-cycle implication.
`define FLCFIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("flcfir assertion failed");

`endif

@@ rtl/flcfir_pkg.sv @@
package flcfir_pkg;

  localparam int MAX_TAPS   = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 6;
  localparam int TIDX_W     = 5;
  localparam int RES_W      = 37;
  localparam int PROD_W     = 2 * SAMPLE_W;
  // Wide enough to hold MAX_TAPS itself after clamping.
  localparam int TU_W       = CFG_W + 1;
  localparam int FL_W       = (MAX_TAPS < 3) ? 1 : $clog2(MAX_TAPS);

  // Adder tree: full binary tree, at least two leaves.
  localparam int TREE_LEAVES = (MAX_TAPS < 2) ? 2 : (1 << $clog2(MAX_TAPS));
  localparam int TREE_LEVELS = $clog2(TREE_LEAVES);
  localparam int TREE_NODES  = TREE_LEAVES - 1;

  // Stream packing.
  localparam int VAL_LSB    = TIDX_W;
  localparam int S_TDATA_W  = ((TIDX_W + SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

  typedef enum logic {
    MODE_COEF   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef struct packed {
    logic adv;      // whole pipeline moves on this edge
    logic shift;    // delay line takes a new entry
    logic clear;    // delay line returns to zero
    logic coef_we;  // this cell's coefficient is written
    logic tap_en;   // this cell lies within the taps in use
  } cell_ctrl_t;

  // Number of taps actually used for a given register value.
  function automatic logic [TU_W-1:0] taps_used(input logic [CFG_W-1:0] tc);
    logic [TU_W-1:0] res;
    if (tc == '0) begin
      res = TU_W'(1);
    end else if (32'(tc) > MAX_TAPS) begin
      res = TU_W'(MAX_TAPS);
    end else begin
      res = TU_W'(tc);
    end
    return res;
  endfunction

endpackage

@@ rtl/flcfir_cell.sv @@
module flcfir_cell
  import flcfir_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] din_i,
  input  logic signed [SAMPLE_W-1:0] coef_i,
  output logic signed [SAMPLE_W-1:0] tap_o,
  output logic signed [RES_W-1:0]    prod_o
);

  logic signed [SAMPLE_W-1:0] tap_q, tap_d;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic signed [PROD_W-1:0]   mult;
  logic signed [RES_W-1:0]    prod_q, prod_d;

  // One delay line entry; it must read as zero after reset and after a column.
  always_comb begin
    if (ctrl_i.shift) begin
      tap_d = din_i;
    end else if (ctrl_i.clear) begin
      tap_d = '0;
    end else begin
      tap_d = tap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.coef_we) begin
      coef_q <= coef_i;
    end
  end

  assign mult   = coef_q * tap_q;
  assign prod_d = ctrl_i.tap_en ? RES_W'(mult) : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q <= prod_d;
    end
  end

  assign tap_o  = tap_q;
  assign prod_o = prod_q;

endmodule

@@ rtl/flcfir_tree.sv @@
module flcfir_tree
  import flcfir_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic signed [RES_W-1:0] leaf_i [MAX_TAPS],
  input  logic                    vld_i,
  input  logic                    last_i,
  output logic signed [RES_W-1:0] sum_o,
  output logic                    vld_o,
  output logic                    last_o
);

  logic signed [RES_W-1:0] leaf_w [TREE_LEAVES];
  logic signed [RES_W-1:0] node_q [TREE_NODES];
  logic [TREE_LEVELS-1:0]  vld_q, last_q;

  for (genvar l = 0; l < TREE_LEAVES; l++) begin : g_leaf
    if (l < MAX_TAPS) begin : g_used
      assign leaf_w[l] = leaf_i[l];
    end else begin : g_pad
      assign leaf_w[l] = '0;
    end
  end

  // Heap layout: node n adds children 2n+1 and 2n+2; the bottom row reads leaves.
  for (genvar n = 0; n < TREE_NODES; n++) begin : g_node
    if (2 * n + 1 >= TREE_NODES) begin : g_bottom
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          node_q[n] <= leaf_w[2*n+1-TREE_NODES] + leaf_w[2*n+2-TREE_NODES];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
    end else if (adv_i) begin
      vld_q  <= TREE_LEVELS'({vld_q, vld_i});
      last_q <= TREE_LEVELS'({last_q, last_i});
    end
  end

  assign sum_o  = node_q[0];
  assign vld_o  = vld_q[TREE_LEVELS-1];
  assign last_o = last_q[TREE_LEVELS-1];

endmodule

@@ rtl/full_linear_convolution_fir_unit.sv @@
// Full linear convolution FIR unit: y[n] = sum of h[m]*x[n-m] over the taps in use.
// Input stream (s_axis): tuser selects the transaction kind. A coefficient
// transaction writes tap tap_index with value; a sample transaction shifts value
// into the delay line and yields one result. tlast on a sample closes the column:
// the unit then shifts tap_count-1 zeros through the line itself, yielding the
// tail of the convolution, marks the final result with tlast and clears the line.
// Output stream (m_axis): one 37-bit exact sum per result, tlast on a column's end.
// The user must write the tap count register (cfg_we_i/cfg_wdata_i) only while
// idle; the unit does not enforce it. Throughput is one transaction per cycle
// while no column's tail runs and the receiver does not stall; during the tail
// s_axis_tready stays low (tap_count clamped to 1..MAX_TAPS). From input to
// output a value passes one delay line stage, one multiplier stage in each
// cell and the registered adder tree, whose root is the output register.
// When the receiver stalls the whole pipeline holds and s_axis_tready falls.
// Reset clears the delay line, the pipeline valid bits and sets tap_count to one;
// coefficients are undefined until written.
`include "full_linear_convolution_fir_unit_macros.svh"

module full_linear_convolution_fir_unit
  import flcfir_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: tap_count.
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Input stream. tdata: tap_index[4:0], value[20:5], zero fill. tuser: mode.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  // Output stream. tdata: result[36:0], zero fill. tlast: last_of_column.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [CFG_W-1:0]           tap_count_q;
  logic [TU_W-1:0]            k;
  logic [TIDX_W-1:0]          tap_index;
  logic signed [SAMPLE_W-1:0] value;
  mode_e                      mode;

  logic adv, accept, samp_acc, coef_acc, push, item_last, col_end;
  logic signed [SAMPLE_W-1:0] push_val;

  logic              flush_q, flush_d;
  logic [FL_W-1:0]   flush_left_q, flush_left_d;
  logic              clear_q;
  logic              v1_q, last1_q, v2_q, last2_q;

  logic signed [SAMPLE_W-1:0] tap_w  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] din_w  [MAX_TAPS];
  logic signed [RES_W-1:0]    prod_w [MAX_TAPS];
  cell_ctrl_t                 ctrl_w [MAX_TAPS];

  logic signed [RES_W-1:0]    sum;

  // Field unpacking.
  assign tap_index = s_axis_tdata[TIDX_W-1:0];
  assign value     = $signed(s_axis_tdata[VAL_LSB+SAMPLE_W-1:VAL_LSB]);
  assign mode      = mode_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  assign k = taps_used(tap_count_q);

  // The whole pipeline moves together unless a finished result is waiting.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !flush_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign samp_acc      = accept && (mode == MODE_SAMPLE);
  assign coef_acc      = accept && (mode == MODE_COEF);

  // A push is either an accepted sample or one zero of a column's tail.
  assign push     = samp_acc || (adv && flush_q);
  assign push_val = samp_acc ? value : '0;

  always_comb begin
    if (flush_q) begin
      item_last = (flush_left_q == FL_W'(1));
    end else begin
      item_last = s_axis_tlast && (k == TU_W'(1));
    end
  end

  assign col_end = push && item_last;

  // Tail sequencer: counts the zeros still to be shifted in.
  always_comb begin
    flush_d      = flush_q;
    flush_left_d = flush_left_q;
    if (samp_acc && s_axis_tlast && (k != TU_W'(1))) begin
      flush_d      = 1'b1;
      flush_left_d = FL_W'(k - TU_W'(1));
    end else if (flush_q && adv) begin
      flush_left_d = flush_left_q - FL_W'(1);
      if (flush_left_q == FL_W'(1)) begin
        flush_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q      <= 1'b0;
      flush_left_q <= '0;
      clear_q      <= 1'b0;
      v1_q         <= 1'b0;
      last1_q      <= 1'b0;
      v2_q         <= 1'b0;
      last2_q      <= 1'b0;
    end else begin
      flush_q      <= flush_d;
      flush_left_q <= flush_left_d;
      if (adv) begin
        // The column end sets clear_q, which clears the line on a later advance so
        // the multipliers still see it; a new sample may enter on that same edge.
        clear_q <= col_end;
        v1_q    <= push;
        last1_q <= col_end;
        v2_q    <= v1_q;
        last2_q <= last1_q;
      end
    end
  end

  // Row of cells: each holds one delay line entry and one coefficient.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign din_w[i] = push_val;
    end else begin : g_rest
      assign din_w[i] = clear_q ? '0 : tap_w[i-1];
    end

    assign ctrl_w[i].adv     = adv;
    assign ctrl_w[i].shift   = push;
    assign ctrl_w[i].clear   = adv && clear_q;
    assign ctrl_w[i].coef_we = coef_acc && (32'(tap_index) == i);
    assign ctrl_w[i].tap_en  = (i < 32'(k));

    flcfir_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_w[i]),
      .din_i  (din_w[i]),
      .coef_i (value),
      .tap_o  (tap_w[i]),
      .prod_o (prod_w[i])
    );
  end

  flcfir_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .leaf_i (prod_w),
    .vld_i  (v2_q),
    .last_i (last2_q),
    .sum_o  (sum),
    .vld_o  (m_axis_tvalid),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'($unsigned(sum));

  // While a column's tail is running no new transaction may enter.
  `FLCFIR_ASSERT_IMPL(a_tail_blocks_input, flush_q, !s_axis_tready)
  // The final push of a column always arms the clear of the delay line.
  `FLCFIR_ASSERT_NEXT(a_col_end_clears, adv && col_end, clear_q)
  // A clear without a new entry leaves the far end of the line at zero.
  `FLCFIR_ASSERT_NEXT(a_clear_empties, adv && clear_q && !push, tap_w[MAX_TAPS-1] == '0)
  // Each step of the tail counts down by exactly one.
  `FLCFIR_ASSERT_NEXT(a_tail_counts, flush_q && adv && (flush_left_q != FL_W'(1)),
                      flush_left_q == $past(flush_left_q) - FL_W'(1))

endmodule

@@ tb/tb_full_linear_convolution_fir_unit.sv @@
module tb_full_linear_convolution_fir_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import flcfir_pkg::*;

  // This margin lets a coefficient transaction, which yields nothing to wait for,
  // drain through the pipeline before the tap count moves.
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SET  = 16;

  localparam logic signed [SAMPLE_W-1:0] VAL_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] VAL_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};

  // One input transaction as the stimulus sees it.
  typedef struct {
    mode_e                      mode;
    logic [TIDX_W-1:0]          tap;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } fir_item_t;

  // One output transaction of the convolution.
  typedef struct {
    logic signed [RES_W-1:0] sum;
    logic                    last;
  } conv_out_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_BURSTY
  } rx_pattern_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  full_linear_convolution_fir_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Transactions waiting to be driven, and convolution outputs still owed by the unit.
  fir_item_t stim_q[$];
  conv_out_t conv_out_q[$];

  // Predictor state: the delay line, the kernel and the tap count register.
  logic signed [SAMPLE_W-1:0] tap_line [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] kernel   [MAX_TAPS];
  logic [CFG_W-1:0]           tc_model = CFG_W'(1);

  // Stimulus side: the tap count it has programmed and the taps it has loaded,
  // so that no sample ever reaches a coefficient that was never written.
  logic [CFG_W-1:0]    tc_plan    = CFG_W'(1);
  logic [MAX_TAPS-1:0] tap_loaded = '0;

  // Flow control of both sides.
  logic        tx_gaps     = 1'b0;
  rx_pattern_e rx_mode     = RX_OPEN;
  int          gap_left    = 0;
  int          burst_left  = 0;
  int          rx_hold     = 0;
  int          quiet_count = 0;

  int n_errors   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_columns  = 0;
  int n_settings = 1;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // A register value of zero still uses one tap, and anything above the
  // delay line length is clipped to it.
  function automatic int taps_active(input logic [CFG_W-1:0] tc);
    if (tc == '0) return 1;
    if (int'(tc) > MAX_TAPS) return MAX_TAPS;
    return int'(tc);
  endfunction

  // Shifts one sample into the delay line and returns the exact sum over k taps.
  function automatic logic signed [RES_W-1:0] conv_step(
    input logic signed [SAMPLE_W-1:0] x,
    input int                         k
  );
    longint acc;
    acc = 0;
    for (int i = MAX_TAPS - 1; i > 0; i--) tap_line[i] = tap_line[i - 1];
    tap_line[0] = x;
    for (int i = 0; i < k; i++) acc += longint'(kernel[i]) * longint'(tap_line[i]);
    return RES_W'(acc);
  endfunction

  // Works out every output that an accepted transaction causes. A closing
  // sample also pushes k-1 zeros through the line for the convolution tail.
  function automatic void predict_fir(input fir_item_t it);
    int        k;
    conv_out_t o;
    if (it.mode == MODE_COEF) begin
      kernel[it.tap] = it.value;
    end else begin
      k      = taps_active(tc_model);
      o.sum  = conv_step(it.value, k);
      o.last = it.last && (k == 1);
      conv_out_q.push_back(o);
      if (it.last) begin
        for (int j = 1; j < k; j++) begin
          o.sum  = conv_step('0, k);
          o.last = (j == k - 1);
          conv_out_q.push_back(o);
        end
        foreach (tap_line[i]) tap_line[i] = '0;
      end
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // The last flag on a coefficient transaction has no meaning, so it is
  // driven either way to show that the unit ignores it.
  function automatic void push_coef(
    input logic [TIDX_W-1:0]          tap,
    input logic signed [SAMPLE_W-1:0] v,
    input logic                       last
  );
    fir_item_t it;
    it.mode         = MODE_COEF;
    it.tap          = tap;
    it.value        = v;
    it.last         = last;
    tap_loaded[tap] = 1'b1;
    stim_q.push_back(it);
  endfunction

  // The tap index field is ignored on samples and carries random bits.
  function automatic void push_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
    fir_item_t it;
    it.mode  = MODE_SAMPLE;
    it.tap   = TIDX_W'($urandom_range(0, MAX_TAPS - 1));
    it.value = v;
    it.last  = last;
    stim_q.push_back(it);
  endfunction

  // Returns once every transaction has gone in and every result has come out,
  // then lets the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || conv_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_tap_count(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    tc_plan = v;
    n_settings++;
  endtask

  // Loads any tap still missing for the current count, then queues columns of
  // random length. Mostly they are short; now and then one is long enough to
  // fill every tap in use. A column cut off at the end of the set stays open, so
  // the next tap count takes effect in the middle of it.
  task automatic random_items(input int n);
    int k;
    int made;
    int len;
    k = taps_active(tc_plan);
    for (int i = 0; i < k; i++) begin
      if (!tap_loaded[i]) push_coef(TIDX_W'(i), rand_value(), 1'b0);
    end
    made = 0;
    while (made < n) begin
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(k, 2 * k + 3) : $urandom_range(1, 5);
      for (int i = 0; i < len && made < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_coef(TIDX_W'($urandom_range(0, MAX_TAPS - 1)), rand_value(),
                    1'($urandom_range(0, 1)));
          made++;
        end
        push_sample(rand_value(), i == len - 1);
        made++;
      end
    end
  endtask

  // Driver: presents queued transactions in bursts of random length. A
  // transaction stays on the bus until the unit accepts it; a new one, or a
  // gap, follows only after that.
  always @(posedge clk_i) begin : driver
    fir_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || stim_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        it = stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= S_TDATA_W'({it.value, it.tap});
        s_axis_tlast  <= it.last;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= tx_gaps ? $urandom_range(0, 6) : 0;
        end
      end
    end
  end

  // Receiver: always ready, ready at random, or long stalls between runs of
  // readiness, as the current set of the run chooses.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          m_axis_tready <= 1'b1;
        end
        RX_RANDOM: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
          end else begin
            m_axis_tready <= !m_axis_tready;
            rx_hold       <= m_axis_tready ? $urandom_range(1, 20) : $urandom_range(0, 10);
          end
        end
      endcase
    end
  end

  // Monitor: checks each output transaction against the oldest prediction,
  // then feeds the predictor with the input transaction and register write of
  // the same edge.
  always @(posedge clk_i) begin : monitor
    conv_out_t               want;
    logic signed [RES_W-1:0] got_sum;
    fir_item_t               seen;
    if (!rst_ni) begin
      foreach (tap_line[i]) tap_line[i] = '0;
      foreach (kernel[i]) kernel[i] = '0;
      tc_model = CFG_W'(1);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = m_axis_tdata[RES_W-1:0];
        n_results++;
        if (m_axis_tlast) n_columns++;
        if (conv_out_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: unexpected output: result %0d last %0b", $time, got_sum,
                     m_axis_tlast);
          end
        end else begin
          want = conv_out_q.pop_front();
          if (got_sum !== want.sum || m_axis_tlast !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: output %0d: result %0d (expected %0d), last %0b (expected %0b)",
                       $time, n_results, got_sum, want.sum, m_axis_tlast, want.last);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.mode  = mode_e'(s_axis_tuser);
        seen.tap   = s_axis_tdata[TIDX_W-1:0];
        seen.value = s_axis_tdata[VAL_LSB +: SAMPLE_W];
        seen.last  = s_axis_tlast;
        predict_fir(seen);
        n_accepted++;
      end
      if (cfg_we_i) tc_model = cfg_wdata_i;
    end
  end

  // Watchdog: a correct run never goes this long without a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d outputs still owed", $time, conv_out_q.size());
      $display("tb_full_linear_convolution_fir_unit: errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] tc_sets [10];
    tc_sets = '{6'd0, 6'd63, 6'd5, 6'd33, 6'd2, 6'd17, 6'd1, 6'd12, 6'd32, 6'd7};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Tap count straight from reset, which is a single tap. Coefficient
    // transactions, the highest tap index among them, yield nothing.
    tx_gaps = 1'b0;
    rx_mode = RX_OPEN;
    push_coef('0, VAL_MIN, 1'b1);
    push_sample(VAL_MIN, 1'b0);
    push_sample(VAL_MAX, 1'b0);
    push_coef('1, VAL_MAX, 1'b0);
    push_coef('0, VAL_MAX, 1'b0);
    push_sample(VAL_MAX, 1'b1);
    push_sample(VAL_MIN, 1'b1);
    push_sample('0, 1'b0);
    push_sample('1, 1'b1);

    // Full length kernel of most negative taps against a column of most
    // negative samples: the sum climbs to its largest value and then the
    // tail runs down again.
    write_tap_count(CFG_W'(MAX_TAPS));
    tx_gaps = 1'b1;
    rx_mode = RX_BURSTY;
    for (int i = 0; i < MAX_TAPS; i++) push_coef(TIDX_W'(i), VAL_MIN, 1'b0);
    for (int i = 0; i < MAX_TAPS; i++) push_sample(VAL_MIN, i == MAX_TAPS - 1);
    random_items(ITEMS_PER_SET);

    // Random sets, each under its own tap count and flow control pattern.
    for (int s = 0; s <= $size(tc_sets); s++) begin
      if (s < $size(tc_sets)) write_tap_count(tc_sets[s]);
      else write_tap_count(CFG_W'($urandom_range(0, 63)));
      tx_gaps = (s % 4 != 3);
      rx_mode = rx_pattern_e'(s % 3);
      random_items(ITEMS_PER_SET);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (conv_out_q.size() != 0) n_errors++;

    $display("Covered %0d input transactions over %0d tap count settings %s",
             n_accepted, n_settings, "(zero and above range too).");
    $display("Checked %0d results in %0d closed columns; %0d mismatches.",
             n_results, n_columns, n_errors);
    if (n_errors == 0) begin
      $display("tb_full_linear_convolution_fir_unit: clean");
    end else begin
      $display("tb_full_linear_convolution_fir_unit: errors");
    end
    $finish;
  end

endmodule
